/* src/skgr_pkg.sv */
// Shared types and constants for the stream k-group reverser.
`timescale 1ns / 1ps

package skgr_pkg;

    localparam int MAX_GROUP     = 16;
    localparam int VALUE_BITS    = 16;
    localparam int CFG_BITS      = 5;
    localparam int IDX_BITS      = $clog2(MAX_GROUP);
    localparam int CNT_BITS      = $clog2(MAX_GROUP + 1);
    localparam int BANK_COUNT    = 2;
    localparam int RAM_DEPTH     = BANK_COUNT * MAX_GROUP;
    localparam int RAM_ADDR_BITS = IDX_BITS + 1;
    localparam int RUNQ_DEPTH    = 2;
    localparam int OUTQ_DEPTH    = 4;
    localparam int OUTQ_PTR_BITS = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_BITS = $clog2(OUTQ_DEPTH + 1);

    typedef struct packed {
        logic [VALUE_BITS-1:0] item_value;
        logic                  end_of_list;
    } item_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] out_value;
        logic                  last_of_run;
        logic                  list_done;
    } result_t;

    // One run of results: which bank, how many values, order and end marker.
    typedef struct packed {
        logic                bank;
        logic [CNT_BITS-1:0] count;
        logic                reverse;
        logic                eol;
    } run_desc_t;

    typedef struct packed {
        logic valid;
        logic bank;
    } bank_release_t;

endpackage

/* src/skgr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module skgr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/skgr_front.sv */
// Front end: accepts items, fills the current bank and issues run descriptors.
`timescale 1ns / 1ps

module skgr_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [skgr_pkg::CFG_BITS-1:0]        group_size,
    input  logic                                 push,
    output logic                                 full,
    input  skgr_pkg::item_t                      item,
    output logic                                 ram_we,
    output logic [skgr_pkg::RAM_ADDR_BITS-1:0]   ram_waddr,
    output logic [skgr_pkg::VALUE_BITS-1:0]      ram_wdata,
    output logic                                 run_push,
    output skgr_pkg::run_desc_t                  run_desc,
    input  logic                                 run_q_full,
    input  skgr_pkg::bank_release_t              release_bank
);

    logic [skgr_pkg::IDX_BITS-1:0]   fill_reg, fill_next;
    logic                            cur_bank_reg, cur_bank_next;
    logic [skgr_pkg::BANK_COUNT-1:0] busy_reg, busy_next;
    logic [skgr_pkg::CNT_BITS-1:0]   k_eff;
    logic [skgr_pkg::CNT_BITS-1:0]   new_fill;
    logic                            accept;
    logic                            group_full;

    // Zero acts as one; oversize saturates to the bank depth.
    always_comb
    begin
        if (group_size == '0)
        begin
            k_eff = skgr_pkg::CNT_BITS'(1);
        end
        else if (int'(group_size) > skgr_pkg::MAX_GROUP)
        begin
            k_eff = skgr_pkg::CNT_BITS'(skgr_pkg::MAX_GROUP);
        end
        else
        begin
            k_eff = skgr_pkg::CNT_BITS'(group_size);
        end
    end

    assign full       = busy_reg[cur_bank_reg];
    assign accept     = push && !full;
    assign new_fill   = skgr_pkg::CNT_BITS'(fill_reg) + skgr_pkg::CNT_BITS'(1);
    assign group_full = new_fill >= k_eff;

    assign ram_we    = accept;
    assign ram_waddr = {cur_bank_reg, fill_reg};
    assign ram_wdata = item.item_value;

    assign run_push         = accept && (group_full || item.end_of_list);
    assign run_desc.bank    = cur_bank_reg;
    assign run_desc.count   = new_fill;
    assign run_desc.reverse = group_full;
    assign run_desc.eol     = item.end_of_list;

    always_comb
    begin
        fill_next     = fill_reg;
        cur_bank_next = cur_bank_reg;
        busy_next     = busy_reg;
        if (release_bank.valid)
        begin
            busy_next[release_bank.bank] = 1'b0;
        end
        if (run_push)
        begin
            // Hand the bank to the back end and switch to the other one.
            fill_next               = '0;
            cur_bank_next           = !cur_bank_reg;
            busy_next[cur_bank_reg] = 1'b1;
        end
        else if (accept)
        begin
            fill_next = new_fill[skgr_pkg::IDX_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            cur_bank_reg <= 1'b0;
            busy_reg     <= '0;
        end
        else
        begin
            fill_reg     <= fill_next;
            cur_bank_reg <= cur_bank_next;
            busy_reg     <= busy_next;
        end
    end

    a_run_room: assert property (@(posedge clk) disable iff (!rst_n)
        run_push |-> !run_q_full)
        else $error("run descriptor issued while run queue full");

    a_release_busy: assert property (@(posedge clk) disable iff (!rst_n)
        release_bank.valid |-> busy_reg[release_bank.bank])
        else $error("release of a bank that is not busy");

endmodule

/* src/skgr_run_queue.sv */
// Two-entry queue of run descriptors between front and back end.
`timescale 1ns / 1ps

module skgr_run_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  skgr_pkg::run_desc_t wr_desc,
    output logic                q_full,
    input  logic                rd_en,
    output logic                q_valid,
    output skgr_pkg::run_desc_t rd_desc
);

    skgr_pkg::run_desc_t entry_reg [skgr_pkg::RUNQ_DEPTH];
    logic [$clog2(skgr_pkg::RUNQ_DEPTH)-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [$clog2(skgr_pkg::RUNQ_DEPTH+1)-1:0] count_reg, count_next;
    logic do_wr, do_rd;

    assign q_full  = count_reg == ($clog2(skgr_pkg::RUNQ_DEPTH+1))'(skgr_pkg::RUNQ_DEPTH);
    assign q_valid = count_reg != '0;
    assign rd_desc = entry_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && q_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

/* src/skgr_back.sv */
// Back end: walks each run through the group RAM and queues the results.
`timescale 1ns / 1ps

module skgr_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                run_valid,
    input  skgr_pkg::run_desc_t                 run_desc,
    output logic                                run_pop,
    output logic                                ram_re,
    output logic [skgr_pkg::RAM_ADDR_BITS-1:0]  ram_raddr,
    input  logic [skgr_pkg::VALUE_BITS-1:0]     ram_rdata,
    output skgr_pkg::bank_release_t             release_bank,
    output logic                                empty,
    input  logic                                pop,
    output skgr_pkg::result_t                   result
);

    logic                            active_reg;
    skgr_pkg::run_desc_t             desc_reg;
    logic [skgr_pkg::IDX_BITS-1:0]   step_reg;
    logic [skgr_pkg::IDX_BITS-1:0]   rd_idx;
    logic [skgr_pkg::CNT_BITS-1:0]   last_step;
    logic                            last_read;
    logic                            issue;
    logic                            rd_valid_reg;
    logic                            rd_last_reg;
    logic                            rd_done_reg;

    skgr_pkg::result_t                 oq_reg [skgr_pkg::OUTQ_DEPTH];
    logic [skgr_pkg::OUTQ_PTR_BITS-1:0] oq_head_reg, oq_tail_reg;
    logic [skgr_pkg::OUTQ_CNT_BITS-1:0] oq_count_reg, oq_count_next;
    logic [skgr_pkg::OUTQ_CNT_BITS-1:0] oq_claimed;
    logic                               oq_push, oq_pop;
    skgr_pkg::result_t                  oq_in;

    assign last_step = desc_reg.count - skgr_pkg::CNT_BITS'(1);
    assign last_read = skgr_pkg::CNT_BITS'(step_reg) == last_step;
    assign rd_idx    = desc_reg.reverse ? (last_step[skgr_pkg::IDX_BITS-1:0] - step_reg)
                                        : step_reg;

    // Count the read in flight as taken space so no result is ever dropped.
    assign oq_claimed = oq_count_reg + skgr_pkg::OUTQ_CNT_BITS'(rd_valid_reg);
    assign issue      = active_reg
                        && (oq_claimed < skgr_pkg::OUTQ_CNT_BITS'(skgr_pkg::OUTQ_DEPTH));

    assign ram_re    = issue;
    assign ram_raddr = {desc_reg.bank, rd_idx};

    assign release_bank.valid = issue && last_read;
    assign release_bank.bank  = desc_reg.bank;

    // Load the next run when idle or in the cycle the current one ends.
    assign run_pop = run_valid && (!active_reg || (issue && last_read));

    always_ff @(posedge clk)
    begin
        if (run_pop)
        begin
            desc_reg <= run_desc;
        end
        if (issue)
        begin
            rd_last_reg <= last_read;
            rd_done_reg <= last_read && desc_reg.eol;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            step_reg     <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= issue;
            if (run_pop)
            begin
                active_reg <= 1'b1;
                step_reg   <= '0;
            end
            else if (issue)
            begin
                if (last_read)
                begin
                    active_reg <= 1'b0;
                end
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    assign oq_in.out_value   = ram_rdata;
    assign oq_in.last_of_run = rd_last_reg;
    assign oq_in.list_done   = rd_done_reg;
    assign oq_push           = rd_valid_reg;
    assign oq_pop            = pop && !empty;

    assign empty  = oq_count_reg == '0;
    assign result = oq_reg[oq_head_reg];

    always_comb
    begin
        oq_count_next = oq_count_reg;
        if (oq_push && !oq_pop)
        begin
            oq_count_next = oq_count_reg + 1'b1;
        end
        else if (oq_pop && !oq_push)
        begin
            oq_count_next = oq_count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (oq_push)
        begin
            oq_reg[oq_tail_reg] <= oq_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_head_reg  <= '0;
            oq_tail_reg  <= '0;
            oq_count_reg <= '0;
        end
        else
        begin
            if (oq_push)
            begin
                oq_tail_reg <= oq_tail_reg + 1'b1;
            end
            if (oq_pop)
            begin
                oq_head_reg <= oq_head_reg + 1'b1;
            end
            oq_count_reg <= oq_count_next;
        end
    end

    a_oq_room: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> oq_count_reg < skgr_pkg::OUTQ_CNT_BITS'(skgr_pkg::OUTQ_DEPTH))
        else $error("read data returned with output queue full");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> skgr_pkg::CNT_BITS'(step_reg) < desc_reg.count)
        else $error("read step beyond run length");

    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (issue && last_read && !run_pop) |=> !active_reg)
        else $error("back end stayed active after final read");

endmodule

/* src/stream_k_group_reverser.sv */
// Top level of the stream k-group reverser.
//
// Items enter on a queue-style port: an item is taken at a clock edge with
// push high and full low. Values of a list are gathered into groups of
// group_size; a full group comes out newest first, and a partial group at
// end_of_list comes out in arrival order. Results leave on a queue-style
// port: the oldest result is on result while empty is low, and it is taken
// at an edge with pop high and empty low.
// group_size is written through cfg_wr_en / cfg_wr_data; the user must write
// it only while the block is idle, which the block itself does not enforce.
// Zero acts as one and values above the bank depth saturate. The group RAM
// holds two banks, so one group fills while the previous one drains. A bank
// is handed back only once its last read is issued, so full can rise between
// runs: with large full groups the rate is close to one item per cycle while
// full is low, and lower with a group size of one. After its first result a
// run streams one result per cycle while the output queue has room. A stalled
// receiver fills a four-entry output queue, then the back end pauses; once
// both banks wait, full rises. Reset empties all queues and sets group_size
// to one; the RAM needs no clearing.
`timescale 1ns / 1ps

module stream_k_group_reverser (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [skgr_pkg::CFG_BITS-1:0] cfg_wr_data,
    input  logic                          push,
    output logic                          full,
    input  skgr_pkg::item_t               item,
    output logic                          empty,
    input  logic                          pop,
    output skgr_pkg::result_t             result
);

    logic [skgr_pkg::CFG_BITS-1:0]      group_size_reg;
    logic                               ram_we;
    logic [skgr_pkg::RAM_ADDR_BITS-1:0] ram_waddr;
    logic [skgr_pkg::VALUE_BITS-1:0]    ram_wdata;
    logic                               ram_re;
    logic [skgr_pkg::RAM_ADDR_BITS-1:0] ram_raddr;
    logic [skgr_pkg::VALUE_BITS-1:0]    ram_rdata;
    logic                               run_push;
    skgr_pkg::run_desc_t                run_wr_desc;
    logic                               run_q_full;
    logic                               run_pop;
    logic                               run_valid;
    skgr_pkg::run_desc_t                run_rd_desc;
    skgr_pkg::bank_release_t            release_bank;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_size_reg <= skgr_pkg::CFG_BITS'(1);
        end
        else if (cfg_wr_en)
        begin
            group_size_reg <= cfg_wr_data;
        end
    end

    skgr_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .group_size   (group_size_reg),
        .push         (push),
        .full         (full),
        .item         (item),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .run_push     (run_push),
        .run_desc     (run_wr_desc),
        .run_q_full   (run_q_full),
        .release_bank (release_bank)
    );

    skgr_ram #(
        .WIDTH (skgr_pkg::VALUE_BITS),
        .DEPTH (skgr_pkg::RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    skgr_run_queue u_run_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (run_push),
        .wr_desc (run_wr_desc),
        .q_full  (run_q_full),
        .rd_en   (run_pop),
        .q_valid (run_valid),
        .rd_desc (run_rd_desc)
    );

    skgr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .run_valid    (run_valid),
        .run_desc     (run_rd_desc),
        .run_pop      (run_pop),
        .ram_re       (ram_re),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata),
        .release_bank (release_bank),
        .empty        (empty),
        .pop          (pop),
        .result       (result)
    );

endmodule
